[rtl/core/fbe_pkg.sv]
package fbe_pkg;

    localparam int DW        = 33;
    localparam int MW        = 32;
    localparam int NW        = 30;
    localparam int NORM_TOP  = NW - 1;
    localparam int BW        = 5;
    localparam int QSW       = 2 * NW + 2;
    localparam int LW        = QSW / 2;
    localparam int ISQ_LAT   = QSW / 2;
    localparam int DIV_QW    = 50;
    localparam int DIV_NW    = 80;
    localparam int DIV_LAT   = DIV_QW;
    localparam int FRONT_LAT = 1;
    localparam int NORM_LAT  = 5;
    localparam int MID_LAT   = 6;
    localparam int TAIL_LAT  = 2;
    localparam int TOTAL_LAT = FRONT_LAT + NORM_LAT + ISQ_LAT + DIV_LAT + MID_LAT
                             + DIV_LAT + TAIL_LAT;

    localparam logic        REG_BEND_STIFFNESS = 1'b0;
    localparam logic [31:0] K_RESET            = 32'd65536;

    typedef logic signed [DW-1:0] t_dval;

    typedef struct packed {
        logic [2:0][NW-1:0] mag;
        logic [2:0]         neg;
        logic [BW-1:0]      b;
        logic               zero;
    } t_vec;

endpackage

[rtl/core/fbe_norm.sv]
module fbe_norm import fbe_pkg::*; (
    input  logic              i_clk,
    input  t_dval             i_d [3],
    output t_vec              o_vec,
    output logic [QSW-1:0]    o_sumsq
);

    logic [MW-1:0]     r1_mag [3];
    logic [2:0]        r1_neg;
    logic [MW-1:0]     r1_max;
    logic [MW-1:0]     n1_mag [3];
    logic [2:0]        n1_neg;
    logic [MW-1:0]     n1_max;

    logic [MW-1:0]     r2_mag [3];
    logic [2:0]        r2_neg;
    logic [BW-1:0]     r2_b;
    logic              r2_zero;
    logic [BW-1:0]     n2_b;

    t_vec              r3_vec;
    t_vec              n3_vec;

    t_vec              r4_vec;
    logic [2*NW-1:0]   r4_sq [3];

    t_vec              r5_vec;
    logic [QSW-1:0]    r5_sum;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_neg[i] = i_d[i][DW-1];
            n1_mag[i] = n1_neg[i] ? MW'(-i_d[i]) : MW'(i_d[i]);
        end
        n1_max = n1_mag[0];
        if (n1_mag[1] > n1_max) begin
            n1_max = n1_mag[1];
        end
        if (n1_mag[2] > n1_max) begin
            n1_max = n1_mag[2];
        end
    end

    always_comb begin
        n2_b = '0;
        for (int i = 0; i < MW; i++) begin
            if (r1_max[i]) begin
                n2_b = BW'(i);
            end
        end
    end

    always_comb begin
        logic [MW+NW-1:0] wide;
        n3_vec.neg  = r2_neg;
        n3_vec.b    = r2_b;
        n3_vec.zero = r2_zero;
        for (int i = 0; i < 3; i++) begin
            if (r2_b > BW'(NORM_TOP)) begin
                wide = {NW'(0), r2_mag[i]} >> (r2_b - BW'(NORM_TOP));
            end else begin
                wide = {NW'(0), r2_mag[i]} << (BW'(NORM_TOP) - r2_b);
            end
            n3_vec.mag[i] = wide[NW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r1_mag[i] <= n1_mag[i];
            r2_mag[i] <= r1_mag[i];
            r4_sq[i]  <= (2*NW)'(r3_vec.mag[i]) * (2*NW)'(r3_vec.mag[i]);
        end
        r1_neg  <= n1_neg;
        r1_max  <= n1_max;
        r2_neg  <= r1_neg;
        r2_b    <= n2_b;
        r2_zero <= (r1_max == '0);
        r3_vec  <= n3_vec;
        r4_vec  <= r3_vec;
        r5_vec  <= r4_vec;
        r5_sum  <= QSW'(r4_sq[0]) + QSW'(r4_sq[1]) + QSW'(r4_sq[2]);
    end

    assign o_vec   = r5_vec;
    assign o_sumsq = r5_sum;

endmodule

[rtl/core/fbe_isqrt.sv]
module fbe_isqrt import fbe_pkg::*; (
    input  logic            i_clk,
    input  logic [QSW-1:0]  i_x,
    output logic [LW-1:0]   o_root
);

    logic [QSW-1:0] r_x   [ISQ_LAT];
    logic [QSW-1:0] r_res [ISQ_LAT];

    for (genvar j = 0; j < ISQ_LAT; j++) begin : g_st
        localparam logic [QSW-1:0] BITV = QSW'(1) << (QSW - 2 - 2 * j);
        logic [QSW-1:0] x_in;
        logic [QSW-1:0] res_in;
        logic [QSW-1:0] n_x;
        logic [QSW-1:0] n_res;
        logic [QSW:0]   trial;

        if (j == 0) begin : g_first
            assign x_in   = i_x;
            assign res_in = '0;
        end else begin : g_next
            assign x_in   = r_x[j-1];
            assign res_in = r_res[j-1];
        end

        always_comb begin
            trial = {1'b0, res_in} + {1'b0, BITV};
            if ({1'b0, x_in} >= trial) begin
                n_x   = x_in - trial[QSW-1:0];
                n_res = (res_in >> 1) + BITV;
            end else begin
                n_x   = x_in;
                n_res = res_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            r_x[j]   <= n_x;
            r_res[j] <= n_res;
        end
    end

    assign o_root = r_res[ISQ_LAT-1][LW-1:0];

endmodule

[rtl/core/fbe_divider.sv]
module fbe_divider import fbe_pkg::*; (
    input  logic               i_clk,
    input  logic [DIV_NW-1:0]  i_num,
    input  logic [LW-1:0]      i_den,
    output logic [DIV_QW-1:0]  o_quo
);

    // dividend bits shift out of the top of r_z while quotient bits shift in below
    logic [LW-1:0]     r_rem [DIV_LAT];
    logic [DIV_QW-1:0] r_z   [DIV_LAT];
    logic [LW-1:0]     r_den [DIV_LAT];

    for (genvar j = 0; j < DIV_LAT; j++) begin : g_st
        logic [LW-1:0]     rem_in;
        logic [DIV_QW-1:0] z_in;
        logic [LW-1:0]     den_in;
        logic [LW:0]       trial;
        logic [LW-1:0]     n_rem;
        logic [DIV_QW-1:0] n_z;

        if (j == 0) begin : g_first
            assign rem_in = LW'(i_num[DIV_NW-1:DIV_QW]);
            assign z_in   = i_num[DIV_QW-1:0];
            assign den_in = i_den;
        end else begin : g_next
            assign rem_in = r_rem[j-1];
            assign z_in   = r_z[j-1];
            assign den_in = r_den[j-1];
        end

        always_comb begin
            trial = {rem_in, z_in[DIV_QW-1]};
            if (trial >= {1'b0, den_in}) begin
                n_rem = LW'(trial - {1'b0, den_in});
                n_z   = {z_in[DIV_QW-2:0], 1'b1};
            end else begin
                n_rem = trial[LW-1:0];
                n_z   = {z_in[DIV_QW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[j] <= n_rem;
            r_z[j]   <= n_z;
            r_den[j] <= den_in;
        end
    end

    assign o_quo = r_z[DIV_LAT-1];

endmodule

[rtl/core/filament_bending_energy_force_unit.sv]
// Bending energy / force unit. One request (op plus three bead positions) is taken in every
// cycle that start is high; busy never rises. Each request gives one result, shown for one
// cycle with o_done; the receiver cannot stall the unit. The pipeline is dominated by the
// 31-stage square root and the two banks of 50-stage long dividers (unit vectors, then force
// magnitudes), with a few multiply stages around them. bend_stiffness is to be written over
// the APB port only while no request is in flight; the unit itself does not enforce this.
module filament_bending_energy_force_unit import fbe_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_op,
    input  logic signed [31:0] i_p1_x,
    input  logic signed [31:0] i_p1_y,
    input  logic signed [31:0] i_p1_z,
    input  logic signed [31:0] i_p2_x,
    input  logic signed [31:0] i_p2_y,
    input  logic signed [31:0] i_p2_z,
    input  logic signed [31:0] i_p3_x,
    input  logic signed [31:0] i_p3_y,
    input  logic signed [31:0] i_p3_z,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic               o_done,
    output logic signed [31:0] o_bend_energy,
    output logic signed [31:0] o_f1_x,
    output logic signed [31:0] o_f1_y,
    output logic signed [31:0] o_f1_z,
    output logic signed [31:0] o_f2_x,
    output logic signed [31:0] o_f2_y,
    output logic signed [31:0] o_f2_z,
    output logic signed [31:0] o_f3_x,
    output logic signed [31:0] o_f3_y,
    output logic signed [31:0] o_f3_z,
    output logic               o_degenerate
);

    localparam int U_FRAC = 30;
    localparam int F_FRAC = 16;
    localparam int FMW    = 40;
    localparam logic [63:0]        HALF_Q30  = 64'd536870912;
    localparam logic signed [34:0] ONE_Q30   = 35'sd1073741824;
    localparam logic [63:0]        E_MAX     = 64'd2147483647;
    localparam logic [DIV_QW-1:0]  FORCE_CAP = DIV_QW'(1) << FMW;

    typedef struct packed {
        logic valid;
        logic op;
    } t_ctl;

    typedef struct packed {
        t_vec v1;
        t_vec v2;
    } t_vpair;

    typedef struct packed {
        logic [2:0]    neg1;
        logic [2:0]    neg2;
        logic [BW-1:0] b1;
        logic [BW-1:0] b2;
        logic          degen;
        logic [LW-1:0] l1;
        logic [LW-1:0] l2;
    } t_mid;

    typedef struct packed {
        logic [BW-1:0] b1;
        logic [BW-1:0] b2;
        logic          degen;
        logic [LW-1:0] l1;
        logic [LW-1:0] l2;
    } t_pm;

    typedef struct packed {
        logic [BW-1:0] b1;
        logic [BW-1:0] b2;
        logic          degen;
        logic [31:0]   energy;
        logic [2:0]    wn1;
        logic [2:0]    wn3;
    } t_tl;

    function automatic logic signed [34:0] rnd30(input logic signed [63:0] x);
        logic [63:0] m;
        logic [34:0] r;
        m = x[63] ? 64'(-x) : 64'(x);
        r = 35'((m + HALF_Q30) >> U_FRAC);
        rnd30 = x[63] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
        if (v > 43'sd2147483647) begin
            sat32 = 32'sh7fffffff;
        end else if (v < -43'sd2147483648) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

    // configuration
    logic [31:0] r_k;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_BEND_STIFFNESS) ? r_k : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= K_RESET;
        end else if (cfg_wr && paddr[2] == REG_BEND_STIFFNESS) begin
            r_k <= pwdata;
        end
    end

    // control line
    t_ctl r_ctl [TOTAL_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < TOTAL_LAT; s++) begin
                r_ctl[s] <= '0;
            end
        end else begin
            r_ctl[0] <= '{valid: start && !busy, op: i_op};
            for (int s = 1; s < TOTAL_LAT; s++) begin
                r_ctl[s] <= r_ctl[s-1];
            end
        end
    end

    // bond vectors
    logic signed [31:0] p1 [3];
    logic signed [31:0] p2 [3];
    logic signed [31:0] p3 [3];
    t_dval              r_a_d1 [3];
    t_dval              r_a_d2 [3];

    assign p1 = '{i_p1_x, i_p1_y, i_p1_z};
    assign p2 = '{i_p2_x, i_p2_y, i_p2_z};
    assign p3 = '{i_p3_x, i_p3_y, i_p3_z};

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_a_d1[i] <= DW'(p2[i]) - DW'(p1[i]);
            r_a_d2[i] <= DW'(p3[i]) - DW'(p2[i]);
        end
    end

    t_vec            w_vec1;
    t_vec            w_vec2;
    logic [QSW-1:0]  w_sq1;
    logic [QSW-1:0]  w_sq2;
    logic [LW-1:0]   w_l1;
    logic [LW-1:0]   w_l2;

    fbe_norm u_norm1 (.i_clk(i_clk), .i_d(r_a_d1), .o_vec(w_vec1), .o_sumsq(w_sq1));
    fbe_norm u_norm2 (.i_clk(i_clk), .i_d(r_a_d2), .o_vec(w_vec2), .o_sumsq(w_sq2));

    fbe_isqrt u_isq1 (.i_clk(i_clk), .i_x(w_sq1), .o_root(w_l1));
    fbe_isqrt u_isq2 (.i_clk(i_clk), .i_x(w_sq2), .o_root(w_l2));

    t_vpair r_vs1 [ISQ_LAT];
    t_mid   r_vs2 [DIV_LAT];
    t_vpair vs_end;

    assign vs_end = r_vs1[ISQ_LAT-1];

    always_ff @(posedge i_clk) begin
        r_vs1[0] <= '{v1: w_vec1, v2: w_vec2};
        for (int s = 1; s < ISQ_LAT; s++) begin
            r_vs1[s] <= r_vs1[s-1];
        end
        r_vs2[0] <= '{neg1: vs_end.v1.neg, neg2: vs_end.v2.neg,
                      b1: vs_end.v1.b, b2: vs_end.v2.b,
                      degen: vs_end.v1.zero || vs_end.v2.zero,
                      l1: w_l1, l2: w_l2};
        for (int s = 1; s < DIV_LAT; s++) begin
            r_vs2[s] <= r_vs2[s-1];
        end
    end

    // unit vectors
    logic [DIV_QW-1:0] w_uq1 [3];
    logic [DIV_QW-1:0] w_uq2 [3];

    for (genvar i = 0; i < 3; i++) begin : g_udiv
        logic [DIV_NW-1:0] num1;
        logic [DIV_NW-1:0] num2;
        assign num1 = (DIV_NW'(vs_end.v1.mag[i]) << U_FRAC) + DIV_NW'(w_l1 >> 1);
        assign num2 = (DIV_NW'(vs_end.v2.mag[i]) << U_FRAC) + DIV_NW'(w_l2 >> 1);
        fbe_divider u_div1 (.i_clk(i_clk), .i_num(num1), .i_den(w_l1), .o_quo(w_uq1[i]));
        fbe_divider u_div2 (.i_clk(i_clk), .i_num(num2), .i_den(w_l2), .o_quo(w_uq2[i]));
    end

    t_mid vm_end;
    assign vm_end = r_vs2[DIV_LAT-1];

    t_pm                r_pm [MID_LAT];
    logic signed [31:0] r_p1_u1 [3];
    logic signed [31:0] r_p1_u2 [3];
    logic signed [31:0] r_p2_u1 [3];
    logic signed [31:0] r_p2_u2 [3];
    logic signed [63:0] r_p2_prod [3];
    logic signed [31:0] r_p3_u1 [3];
    logic signed [31:0] r_p3_u2 [3];
    logic signed [31:0] r_p3_cos;
    logic [63:0]        r_p4_e;
    logic signed [31:0] r_p4_u1 [3];
    logic signed [31:0] r_p4_u2 [3];
    logic signed [63:0] r_p4_cu1 [3];
    logic signed [63:0] r_p4_cu2 [3];
    logic [31:0]        r_p5_energy;
    logic [31:0]        r_p5_wm1 [3];
    logic [31:0]        r_p5_wm3 [3];
    logic [2:0]         r_p5_wn1;
    logic [2:0]         r_p5_wn3;
    logic [31:0]        r_p6_energy;
    logic [63:0]        r_p6_num1 [3];
    logic [63:0]        r_p6_num3 [3];
    logic [2:0]         r_p6_wn1;
    logic [2:0]         r_p6_wn3;

    logic signed [31:0] n3_cos;
    logic [31:0]        n4_omc;
    logic [31:0]        n5_energy;
    logic [31:0]        n5_wm1 [3];
    logic [31:0]        n5_wm3 [3];
    logic [2:0]         n5_wn1;
    logic [2:0]         n5_wn3;

    always_comb begin
        logic signed [63:0] sum;
        logic signed [34:0] c;
        sum = r_p2_prod[0] + r_p2_prod[1] + r_p2_prod[2];
        c   = rnd30(sum);
        if (c > ONE_Q30) begin
            n3_cos = 32'(ONE_Q30);
        end else if (c < -ONE_Q30) begin
            n3_cos = 32'(-ONE_Q30);
        end else begin
            n3_cos = c[31:0];
        end
    end

    always_comb begin
        logic signed [34:0] omc;
        omc    = ONE_Q30 - r_p3_cos;
        n4_omc = omc[31:0];
    end

    always_comb begin
        logic [63:0]        e2;
        logic signed [34:0] w1;
        logic signed [34:0] w3;
        e2 = (r_p4_e + HALF_Q30) >> U_FRAC;
        n5_energy = (e2 > E_MAX) ? E_MAX[31:0] : e2[31:0];
        for (int i = 0; i < 3; i++) begin
            w1 = rnd30(r_p4_cu1[i]) - r_p4_u2[i];
            w3 = r_p4_u1[i] - rnd30(r_p4_cu2[i]);
            n5_wn1[i] = w1[34];
            n5_wn3[i] = w3[34];
            n5_wm1[i] = w1[34] ? 32'(-w1) : 32'(w1);
            n5_wm3[i] = w3[34] ? 32'(-w3) : 32'(w3);
        end
    end

    always_ff @(posedge i_clk) begin
        r_pm[0] <= '{b1: vm_end.b1, b2: vm_end.b2, degen: vm_end.degen,
                     l1: vm_end.l1, l2: vm_end.l2};
        for (int s = 1; s < MID_LAT; s++) begin
            r_pm[s] <= r_pm[s-1];
        end
        for (int i = 0; i < 3; i++) begin
            r_p1_u1[i] <= vm_end.neg1[i] ? -$signed(32'(w_uq1[i][LW-1:0]))
                                         :  $signed(32'(w_uq1[i][LW-1:0]));
            r_p1_u2[i] <= vm_end.neg2[i] ? -$signed(32'(w_uq2[i][LW-1:0]))
                                         :  $signed(32'(w_uq2[i][LW-1:0]));
            r_p2_u1[i]   <= r_p1_u1[i];
            r_p2_u2[i]   <= r_p1_u2[i];
            r_p2_prod[i] <= r_p1_u1[i] * r_p1_u2[i];
            r_p3_u1[i]   <= r_p2_u1[i];
            r_p3_u2[i]   <= r_p2_u2[i];
            r_p4_u1[i]   <= r_p3_u1[i];
            r_p4_u2[i]   <= r_p3_u2[i];
            r_p4_cu1[i]  <= r_p3_cos * r_p3_u1[i];
            r_p4_cu2[i]  <= r_p3_cos * r_p3_u2[i];
            r_p5_wm1[i]  <= n5_wm1[i];
            r_p5_wm3[i]  <= n5_wm3[i];
            r_p6_num1[i] <= 64'(r_k) * 64'(r_p5_wm1[i]);
            r_p6_num3[i] <= 64'(r_k) * 64'(r_p5_wm3[i]);
        end
        r_p3_cos    <= n3_cos;
        r_p4_e      <= 64'(r_k) * 64'(n4_omc);
        r_p5_energy <= n5_energy;
        r_p5_wn1    <= n5_wn1;
        r_p5_wn3    <= n5_wn3;
        r_p6_energy <= r_p5_energy;
        r_p6_wn1    <= r_p5_wn1;
        r_p6_wn3    <= r_p5_wn3;
    end

    // force magnitudes: floor(k |w| 2^16 / L')
    t_pm pm_end;
    assign pm_end = r_pm[MID_LAT-1];

    logic [DIV_QW-1:0] w_fq1 [3];
    logic [DIV_QW-1:0] w_fq3 [3];

    for (genvar i = 0; i < 3; i++) begin : g_fdiv
        logic [DIV_NW-1:0] num1;
        logic [DIV_NW-1:0] num3;
        assign num1 = DIV_NW'(r_p6_num1[i]) << F_FRAC;
        assign num3 = DIV_NW'(r_p6_num3[i]) << F_FRAC;
        fbe_divider u_div1 (.i_clk(i_clk), .i_num(num1), .i_den(pm_end.l1), .o_quo(w_fq1[i]));
        fbe_divider u_div3 (.i_clk(i_clk), .i_num(num3), .i_den(pm_end.l2), .o_quo(w_fq3[i]));
    end

    t_tl r_tl [DIV_LAT];
    t_tl tl_end;
    assign tl_end = r_tl[DIV_LAT-1];

    always_ff @(posedge i_clk) begin
        r_tl[0] <= '{b1: pm_end.b1, b2: pm_end.b2, degen: pm_end.degen,
                     energy: r_p6_energy, wn1: r_p6_wn1, wn3: r_p6_wn3};
        for (int s = 1; s < DIV_LAT; s++) begin
            r_tl[s] <= r_tl[s-1];
        end
    end

    logic signed [FMW:0] r_p7_f1 [3];
    logic signed [FMW:0] r_p7_f3 [3];
    logic                r_p7_degen;
    logic [31:0]         r_p7_energy;
    logic signed [FMW:0] n7_f1 [3];
    logic signed [FMW:0] n7_f3 [3];

    always_comb begin
        logic [DIV_QW-1:0] q1;
        logic [DIV_QW-1:0] q3;
        logic [FMW-1:0]    m1;
        logic [FMW-1:0]    m3;
        for (int i = 0; i < 3; i++) begin
            q1 = w_fq1[i] >> tl_end.b1;
            q3 = w_fq3[i] >> tl_end.b2;
            if (q1 >= FORCE_CAP) begin
                q1 = FORCE_CAP;
            end
            if (q3 >= FORCE_CAP) begin
                q3 = FORCE_CAP;
            end
            m1 = FMW'((q1 + DIV_QW'(1)) >> 1);
            m3 = FMW'((q3 + DIV_QW'(1)) >> 1);
            n7_f1[i] = tl_end.wn1[i] ? -$signed({1'b0, m1}) : $signed({1'b0, m1});
            n7_f3[i] = tl_end.wn3[i] ? -$signed({1'b0, m3}) : $signed({1'b0, m3});
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_p7_f1[i] <= n7_f1[i];
            r_p7_f3[i] <= n7_f3[i];
        end
        r_p7_degen  <= tl_end.degen;
        r_p7_energy <= tl_end.energy;
    end

    // result select
    logic signed [31:0] r_out_e;
    logic signed [31:0] r_out_f1 [3];
    logic signed [31:0] r_out_f2 [3];
    logic signed [31:0] r_out_f3 [3];
    logic               r_out_degen;
    logic               sel_op;

    assign sel_op = r_ctl[TOTAL_LAT-2].op;

    always_ff @(posedge i_clk) begin
        logic signed [42:0] s2;
        r_out_degen <= r_p7_degen;
        r_out_e     <= (r_p7_degen || sel_op) ? '0 : $signed(r_p7_energy);
        for (int i = 0; i < 3; i++) begin
            s2 = -(r_p7_f1[i] + r_p7_f3[i]);
            if (r_p7_degen || !sel_op) begin
                r_out_f1[i] <= '0;
                r_out_f2[i] <= '0;
                r_out_f3[i] <= '0;
            end else begin
                r_out_f1[i] <= sat32(43'(r_p7_f1[i]));
                r_out_f2[i] <= sat32(s2);
                r_out_f3[i] <= sat32(43'(r_p7_f3[i]));
            end
        end
    end

    assign o_done        = r_ctl[TOTAL_LAT-1].valid;
    assign o_degenerate  = r_out_degen;
    assign o_bend_energy = r_out_e;
    assign o_f1_x        = r_out_f1[0];
    assign o_f1_y        = r_out_f1[1];
    assign o_f1_z        = r_out_f1[2];
    assign o_f2_x        = r_out_f2[0];
    assign o_f2_y        = r_out_f2[1];
    assign o_f2_z        = r_out_f2[2];
    assign o_f3_x        = r_out_f3[0];
    assign o_f3_y        = r_out_f3[1];
    assign o_f3_z        = r_out_f3[2];

endmodule

[rtl/core/fbe_checker.sv]
module fbe_checker import fbe_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_done,
    input logic               o_degenerate,
    input logic signed [31:0] o_bend_energy,
    input logic signed [31:0] o_f1_x,
    input logic signed [31:0] o_f1_y,
    input logic signed [31:0] o_f1_z,
    input logic signed [31:0] o_f2_x,
    input logic signed [31:0] o_f2_y,
    input logic signed [31:0] o_f2_z,
    input logic signed [31:0] o_f3_x,
    input logic signed [31:0] o_f3_y,
    input logic signed [31:0] o_f3_z
);

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##TOTAL_LAT o_done)
        else $error("request did not complete at fixed latency");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, TOTAL_LAT))
        else $error("result without matching request");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_degenerate) |->
            (o_bend_energy == 0 && o_f1_x == 0 && o_f1_y == 0 && o_f1_z == 0 &&
             o_f2_x == 0 && o_f2_y == 0 && o_f2_z == 0 &&
             o_f3_x == 0 && o_f3_y == 0 && o_f3_z == 0))
        else $error("degenerate result not zero");

    a_energy_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_bend_energy[31])
        else $error("negative bending energy");

endmodule

bind filament_bending_energy_force_unit fbe_checker u_fbe_checker (.*);
